[design/scm_pkg.sv]
`default_nettype none
package scm_pkg;
   localparam int QUEUE_DEPTH = 64;
   localparam int FIFO_AW = $clog2(QUEUE_DEPTH);
   localparam int FIFO_LW = $clog2(QUEUE_DEPTH + 1);

   typedef logic [FIFO_AW-1:0] fifo_ptr_type;
   typedef logic [FIFO_LW-1:0] fifo_level_type;

   // item opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // register offsets
   localparam logic [9:0] ADDR_GCR  = 10'h004;
   localparam logic [9:0] ADDR_TCR  = 10'h008;
   localparam logic [9:0] ADDR_FCR  = 10'h018;
   localparam logic [9:0] ADDR_FSR  = 10'h01c;
   localparam logic [9:0] ADDR_CCR  = 10'h024;
   localparam logic [9:0] ADDR_BC   = 10'h030;
   localparam logic [9:0] ADDR_TC   = 10'h034;
   localparam logic [9:0] ADDR_TXD  = 10'h200;
   localparam logic [9:0] ADDR_RXD  = 10'h300;
endpackage
`default_nettype wire

[design/scm_if.sv]
`default_nettype none
interface scm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [9:0]  address;
   logic [31:0] write_data;
   logic        miso;
   modport source (output valid, op, address, write_data, miso, input ready);
   modport sink (input valid, op, address, write_data, miso, output ready);
endinterface

interface scm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        sclk;
   logic        mosi;
   logic [3:0]  select_lines;
   logic        busy_res;
   modport source (output valid, read_data, sclk, mosi, select_lines, busy_res,
                   input ready);
   modport sink (input valid, read_data, sclk, mosi, select_lines, busy_res,
                 output ready);
endinterface
`default_nettype wire

[design/scm_ram.sv]
`default_nettype none
module scm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[design/scm_fifo.sv]
`default_nettype none
module scm_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    clear,
   input  wire logic                    push,
   input  wire logic [7:0]              push_data,
   input  wire logic                    pop,
   output scm_pkg::fifo_level_type      level,
   output logic      [7:0]              rd_data
);
   import scm_pkg::*;

   fifo_ptr_type   head_ff, head_in;
   fifo_level_type level_ff, level_in;
   logic [FIFO_AW:0] slot_sum;
   fifo_ptr_type   slot;
   logic           do_push, do_pop;

   assign do_push = push && (level_ff < FIFO_LW'(QUEUE_DEPTH));
   assign do_pop  = pop && (level_ff != '0);
   assign slot_sum = (FIFO_AW+1)'(head_ff) + (FIFO_AW+1)'(level_ff);

   always_comb begin
      // wrap the write slot
      if (slot_sum >= (FIFO_AW+1)'(QUEUE_DEPTH)) begin
         slot = FIFO_AW'(slot_sum - (FIFO_AW+1)'(QUEUE_DEPTH));
      end else begin
         slot = FIFO_AW'(slot_sum);
      end
      head_in  = head_ff;
      level_in = level_ff;
      if (clear) begin
         head_in  = '0;
         level_in = '0;
      end else if (do_push) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop) begin
         head_in  = (head_ff == FIFO_AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

   scm_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (do_push && !clear),
      .wr_addr (slot),
      .wr_data (push_data),
      .rd_en   (do_pop && !clear),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );
endmodule
`default_nettype wire

[design/spi_master_fifo_controller.sv]
`default_nettype none
// channel    dir   handshake      word
// req_chan   in    valid/ready    op, address, write_data, miso
// rsp_chan   out   valid/ready    read_data, sclk, mosi, select_lines, busy_res
//
// one word per cycle while rsp ready keeps up; each accepted word gives one response word
// a pop reads the fifo ram at the accept edge, and the data shows together
// with the response word or as the shifter contents
// reset is synchronous, clears all control state and both fifo pointers
// req ready drops only while a response waits and rsp ready is low
module spi_master_fifo_controller (
   input wire logic clock,
   input wire logic reset,
   scm_req_if.sink   req_chan,
   scm_rsp_if.source rsp_chan
);
   import scm_pkg::*;

   logic [31:0] gc_ff, gc_in, tc_ff, tc_in, rd_ff, rd_in;
   logic [12:0] cc_ff, cc_in;
   logic [23:0] burst_ff, burst_in, send_ff, send_in, done_ff, done_in;
   logic [7:0]  shifter_ff, shifter_in, sh_eff, tx_q, rx_q;
   logic [3:0]  bitpos_ff, bitpos_in;
   logic [15:0] timer_ff, timer_in, hp;
   logic        phase_ff, phase_in, latch_ff, latch_in;
   logic        tx_pend_ff, tx_pend_in, rx_pend_ff, rx_pend_in;
   logic        out_valid_ff;
   logic        accept;
   logic        tx_clear, rx_clear, tx_push, tx_pop, rx_push, rx_pop;
   logic [7:0]  rx_push_data;
   fifo_level_type tx_level, rx_level;
   logic        busy, line_lvl, act_low;
   logic [1:0]  sel;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   // shifter waits on the tx ram after a pop
   assign sh_eff = tx_pend_ff ? tx_q : shifter_ff;

   always_comb begin
      gc_in = gc_ff; tc_in = tc_ff; cc_in = cc_ff;
      burst_in = burst_ff; send_in = send_ff; done_in = done_ff;
      shifter_in = sh_eff; bitpos_in = bitpos_ff; timer_in = timer_ff;
      phase_in = phase_ff; latch_in = latch_ff;
      tx_pend_in = 1'b0; rx_pend_in = 1'b0; rd_in = '0;
      tx_clear = 1'b0; rx_clear = 1'b0; tx_push = 1'b0; tx_pop = 1'b0;
      rx_push = 1'b0; rx_pop = 1'b0; rx_push_data = '0;
      hp = cc_ff[12] ? 16'(cc_ff[7:0]) + 16'd1 : 16'd1 << cc_ff[11:8];
      if (accept) begin
         case (req_chan.op)
            OP_TICK: begin
               if (tc_ff[31] && gc_ff[0]) begin
                  timer_in = timer_ff + 16'd1;
                  if (timer_in >= hp) begin
                     timer_in = '0;
                     if (!phase_ff) begin
                        latch_in = req_chan.miso;
                        phase_in = 1'b1;
                     end else begin
                        phase_in = 1'b0;
                        shifter_in = {sh_eff[6:0], latch_ff};
                        bitpos_in = bitpos_ff + 4'd1;
                        if (bitpos_in >= 4'd8) begin
                           rx_push = 1'b1;
                           rx_push_data = shifter_in;
                           done_in = done_ff + 24'd1;
                           bitpos_in = '0;
                           if (done_in >= burst_ff) begin
                              tc_in[31] = 1'b0;
                           end else if (done_in < send_ff) begin
                              tx_pop = 1'b1;
                              tx_pend_in = tx_level != '0;
                              shifter_in = '0;
                           end else begin
                              shifter_in = '0;
                           end
                        end
                     end
                  end
               end
            end
            OP_READ: begin
               case (req_chan.address)
                  ADDR_GCR: rd_in = gc_ff;
                  ADDR_TCR: rd_in = tc_ff;
                  ADDR_FSR: rd_in = {16'(tx_level), 16'(rx_level)};
                  ADDR_CCR: rd_in = 32'(cc_ff);
                  ADDR_BC:  rd_in = 32'(burst_ff);
                  ADDR_TC:  rd_in = 32'(send_ff);
                  ADDR_RXD: begin
                     rx_pop = 1'b1;
                     rx_pend_in = rx_level != '0;
                  end
                  default: rd_in = '0;
               endcase
            end
            OP_WRITE: begin
               case (req_chan.address)
                  ADDR_GCR: begin
                     gc_in = {1'b0, req_chan.write_data[30:0]};
                     if (req_chan.write_data[31]) begin
                        // soft reset: fifos and engine
                        tx_clear = 1'b1; rx_clear = 1'b1;
                        tc_in[31] = 1'b0; done_in = '0; shifter_in = '0;
                        bitpos_in = '0; timer_in = '0; phase_in = 1'b0;
                        latch_in = 1'b0;
                     end
                  end
                  ADDR_TCR: begin
                     tc_in = {tc_ff[31], req_chan.write_data[30:0]};
                     if (!tc_ff[31] && req_chan.write_data[31]) begin
                        done_in = '0; shifter_in = '0; bitpos_in = '0;
                        timer_in = '0; phase_in = 1'b0; latch_in = 1'b0;
                        if (burst_ff != '0) begin
                           tc_in[31] = 1'b1;
                           if (send_ff != '0) begin
                              tx_pop = 1'b1;
                              tx_pend_in = tx_level != '0;
                           end
                        end
                     end
                  end
                  ADDR_FCR: begin
                     rx_clear = req_chan.write_data[15];
                     tx_clear = req_chan.write_data[31];
                  end
                  ADDR_CCR: cc_in = req_chan.write_data[12:0];
                  ADDR_BC:  burst_in = req_chan.write_data[23:0];
                  ADDR_TC:  send_in = req_chan.write_data[23:0];
                  ADDR_TXD: tx_push = 1'b1;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff <= '0; tc_ff <= '0; cc_ff <= '0;
         burst_ff <= '0; send_ff <= '0; done_ff <= '0;
         shifter_ff <= '0; bitpos_ff <= '0; timer_ff <= '0;
         phase_ff <= 1'b0; latch_ff <= 1'b0;
         tx_pend_ff <= 1'b0; rx_pend_ff <= 1'b0; rd_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            gc_ff <= gc_in; tc_ff <= tc_in; cc_ff <= cc_in;
            burst_ff <= burst_in; send_ff <= send_in; done_ff <= done_in;
            shifter_ff <= shifter_in; bitpos_ff <= bitpos_in; timer_ff <= timer_in;
            phase_ff <= phase_in; latch_ff <= latch_in;
            tx_pend_ff <= tx_pend_in; rx_pend_ff <= rx_pend_in; rd_ff <= rd_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   scm_fifo u_tx_fifo (
      .clock (clock), .reset (reset), .clear (tx_clear),
      .push (tx_push), .push_data (req_chan.write_data[7:0]),
      .pop (tx_pop), .level (tx_level), .rd_data (tx_q)
   );

   scm_fifo u_rx_fifo (
      .clock (clock), .reset (reset), .clear (rx_clear),
      .push (rx_push), .push_data (rx_push_data),
      .pop (rx_pop), .level (rx_level), .rd_data (rx_q)
   );

   // line levels follow the live state, which holds while a response waits
   assign busy    = tc_ff[31];
   assign act_low = tc_ff[2];
   assign sel     = tc_ff[5:4];
   assign line_lvl = tc_ff[6] ? tc_ff[7] : (busy ? !act_low : act_low);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rsp_chan.select_lines[i] = (2'(i) == sel) ? line_lvl : act_low;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.read_data = rx_pend_ff ? {24'd0, rx_q} : rd_ff;
   assign rsp_chan.sclk      = busy ? (tc_ff[1] ^ tc_ff[0] ^ phase_ff) : tc_ff[1];
   assign rsp_chan.mosi      = busy & sh_eff[7];
   assign rsp_chan.busy_res  = busy;
endmodule
`default_nettype wire

[bench/tb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// the design's interfaces are used directly; this file holds two tiny helper types
package tb_spi_pkg;
   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  address;
      logic [31:0] write_data;
      logic        miso;
   } bus_word_type;
   typedef struct packed {
      logic [31:0] read_data;
      logic        sclk;
      logic        mosi;
      logic [3:0]  select_lines;
      logic        busy_res;
   } line_word_type;
endpackage
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import scm_pkg::*;
   import tb_spi_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   scm_req_if req_chan ();
   scm_rsp_if rsp_chan ();

   spi_master_fifo_controller dut (.clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source));

   initial begin
      forever #10 clock = ~clock;
   end

   // model state
   logic [7:0]  m_txmem [QUEUE_DEPTH];
   logic [7:0]  m_rxmem [QUEUE_DEPTH];
   int unsigned m_txh, m_txl, m_rxh, m_rxl;
   logic [31:0] m_gcr, m_tcr, m_ccr, m_bc, m_tc, m_done;
   logic [7:0]  m_shift;
   int unsigned m_bit, m_timer;
   logic        m_phase, m_latch;

   line_word_type expected_lines [$];
   logic        check_rd [$];
   int          errors = 0;
   int          n_sent = 0, n_got = 0, n_bursts = 0, n_pops = 0;

   function automatic logic [7:0] pop_tx();
      logic [7:0] v;
      if (m_txl == 0) return 8'h00;
      v = m_txmem[m_txh];
      m_txh = (m_txh + 1) % QUEUE_DEPTH;
      m_txl--;
      return v;
   endfunction

   function automatic logic [7:0] pop_rx();
      logic [7:0] v;
      if (m_rxl == 0) return 8'h00;
      v = m_rxmem[m_rxh];
      m_rxh = (m_rxh + 1) % QUEUE_DEPTH;
      m_rxl--;
      return v;
   endfunction

   function automatic void engine_clear();
      m_tcr[31] = 1'b0;
      m_done = 0; m_shift = 0; m_bit = 0; m_timer = 0; m_phase = 0; m_latch = 0;
   endfunction

   function automatic void load_next();
      m_shift = (m_done < m_tc) ? pop_tx() : 8'h00;
      m_bit = 0;
   endfunction

   function automatic void spi_tick(logic miso);
      int unsigned hp;
      if (!m_tcr[31] || !m_gcr[0]) return;
      hp = m_ccr[12] ? m_ccr[7:0] + 1 : (1 << m_ccr[11:8]);
      m_timer = (m_timer + 1) & 16'hffff;
      if (m_timer < hp) return;
      m_timer = 0;
      if (!m_phase) begin
         m_latch = miso;
         m_phase = 1;
         return;
      end
      m_phase = 0;
      m_shift = {m_shift[6:0], m_latch};
      m_bit++;
      if (m_bit < 8) return;
      if (m_rxl < QUEUE_DEPTH) begin
         m_rxmem[(m_rxh + m_rxl) % QUEUE_DEPTH] = m_shift;
         m_rxl++;
      end
      m_done = (m_done + 1) & 32'hffffff;
      if (m_done >= m_bc) begin
         m_tcr[31] = 0;
         m_bit = 0;
      end else load_next();
   endfunction

   // predict the line state and read data for one bus word
   function automatic line_word_type predict_lines(bus_word_type w);
      line_word_type r;
      logic busy, lvl, idle;
      r = '0;
      case (w.op)
         OP_TICK: spi_tick(w.miso);
         OP_READ: begin
            case (w.address)
               ADDR_GCR: r.read_data = m_gcr;
               ADDR_TCR: r.read_data = m_tcr;
               ADDR_FSR: r.read_data = {m_rxl[15:0]} | (m_txl << 16);
               ADDR_CCR: r.read_data = m_ccr;
               ADDR_BC:  r.read_data = m_bc;
               ADDR_TC:  r.read_data = m_tc;
               ADDR_RXD: begin r.read_data = pop_rx(); n_pops++; end
               default:  r.read_data = 0;
            endcase
         end
         OP_WRITE: begin
            busy = m_tcr[31];
            case (w.address)
               ADDR_GCR: begin
                  m_gcr = {1'b0, w.write_data[30:0]};
                  if (w.write_data[31]) begin
                     m_txh = 0; m_txl = 0; m_rxh = 0; m_rxl = 0;
                     engine_clear();
                  end
               end
               ADDR_TCR: begin
                  m_tcr = {busy, w.write_data[30:0]};
                  if (!busy && w.write_data[31]) begin
                     engine_clear();
                     if (m_bc != 0) begin
                        m_tcr[31] = 1;
                        load_next();
                        n_bursts++;
                     end
                  end
               end
               ADDR_FCR: begin
                  if (w.write_data[15]) begin m_rxh = 0; m_rxl = 0; end
                  if (w.write_data[31]) begin m_txh = 0; m_txl = 0; end
               end
               ADDR_CCR: m_ccr = w.write_data & 32'h1fff;
               ADDR_BC:  m_bc = w.write_data & 32'hffffff;
               ADDR_TC:  m_tc = w.write_data & 32'hffffff;
               ADDR_TXD: if (m_txl < QUEUE_DEPTH) begin
                  m_txmem[(m_txh + m_txl) % QUEUE_DEPTH] = w.write_data[7:0];
                  m_txl++;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      busy = m_tcr[31];
      idle = m_tcr[2];
      lvl = m_tcr[6] ? m_tcr[7] : (busy ? ~m_tcr[2] : idle);
      for (int i = 0; i < 4; i++)
         r.select_lines[i] = (i == m_tcr[5:4]) ? lvl : idle;
      r.sclk = busy ? (m_tcr[1] ^ m_tcr[0] ^ m_phase) : m_tcr[1];
      r.mosi = busy ? m_shift[7] : 1'b0;
      r.busy_res = busy;
      return r;
   endfunction

   // directed table; fixed read data where it is obvious at a glance
   typedef struct {
      bus_word_type w;
      logic        fixed;
      logic [31:0] rd;
   } dir_row_type;

   dir_row_type dir_rows [] = '{
      '{'{OP_READ,  ADDR_GCR, 32'h0, 1'b0}, 1'b1, 32'h0},        // after reset
      '{'{OP_READ,  ADDR_FSR, 32'h0, 1'b0}, 1'b1, 32'h0},
      '{'{OP_READ,  ADDR_RXD, 32'h0, 1'b0}, 1'b1, 32'h0},        // empty pop
      '{'{OP_READ,  10'h3ff, 32'h0, 1'b1}, 1'b1, 32'h0},         // unknown
      '{'{OP_WRITE, 10'h038, 32'hffffffff, 1'b0}, 1'b1, 32'h0},
      '{'{OP_WRITE, ADDR_CCR, 32'hffffffff, 1'b0}, 1'b1, 32'h0},
      '{'{OP_READ,  ADDR_CCR, 32'h0, 1'b0}, 1'b1, 32'h1fff},
      '{'{OP_WRITE, ADDR_CCR, 32'h00001000, 1'b0}, 1'b0, 32'h0}, // drs, fast
      '{'{OP_WRITE, ADDR_BC,  32'hffffffff, 1'b0}, 1'b0, 32'h0},
      '{'{OP_READ,  ADDR_BC,  32'h0, 1'b0}, 1'b1, 32'hffffff},
      '{'{OP_WRITE, ADDR_BC,  32'h0, 1'b0}, 1'b0, 32'h0},
      '{'{OP_WRITE, ADDR_TCR, 32'h80000000, 1'b0}, 1'b0, 32'h0}, // zero burst
      '{'{OP_WRITE, ADDR_GCR, 32'h00000083, 1'b0}, 1'b0, 32'h0},
      '{'{OP_WRITE, ADDR_TXD, 32'hffffffa5, 1'b0}, 1'b0, 32'h0},
      '{'{OP_WRITE, ADDR_BC,  32'h2, 1'b0}, 1'b0, 32'h0},
      '{'{OP_WRITE, ADDR_TC,  32'h1, 1'b0}, 1'b0, 32'h0},
      '{'{OP_WRITE, ADDR_TCR, 32'h8000007f, 1'b1}, 1'b0, 32'h0},
      '{'{OP_WRITE, ADDR_TCR, 32'h0, 1'b0}, 1'b0, 32'h0},       // clear ignored
      '{'{OP_TICK,  10'h0, 32'h0, 1'b1}, 1'b0, 32'h0},
      '{'{OP_TICK,  10'h0, 32'h0, 1'b0}, 1'b0, 32'h0},
      '{'{OP_WRITE, ADDR_GCR, 32'h80000001, 1'b0}, 1'b0, 32'h0}, // soft reset
      '{'{OP_READ,  ADDR_GCR, 32'h0, 1'b0}, 1'b1, 32'h1},
      '{'{OP_WRITE, ADDR_FCR, 32'h80008000, 1'b0}, 1'b0, 32'h0},
      '{'{OP_READ,  ADDR_FCR, 32'h0, 1'b0}, 1'b1, 32'h0},
      '{'{{2'd3}, 10'h0, 32'h0, 1'b0}, 1'b0, 32'h0}              // unknown op
   };

   logic fixed_rd [$];
   logic [31:0] fixed_val [$];

   // push one word through the sender side with random gaps
   task automatic send_word(bus_word_type w, logic fx, logic [31:0] fv);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= w.op;
      req_chan.address <= w.address;
      req_chan.write_data <= w.write_data;
      req_chan.miso <= w.miso;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_lines.push_back(predict_lines(w));
      fixed_rd.push_back(fx);
      fixed_val.push_back(fv);
      n_sent++;
   endtask

   function automatic logic [9:0] pick_addr();
      case ($urandom_range(0, 11))
         0: return ADDR_GCR;  1: return ADDR_TCR;  2: return ADDR_FCR;
         3: return ADDR_FSR;  4: return ADDR_CCR;  5: return ADDR_BC;
         6: return ADDR_TC;   7, 8: return ADDR_TXD;  9, 10: return ADDR_RXD;
         default: return 10'($urandom);
      endcase
   endfunction

   logic hold_long = 1'b0;

   // stimulus
   initial begin
      bus_word_type w;
      int k;
      req_chan.valid = 1'b0;
      req_chan.op = OP_TICK;
      req_chan.address = '0;
      req_chan.write_data = '0;
      req_chan.miso = 1'b0;
      m_txh = 0; m_txl = 0; m_rxh = 0; m_rxl = 0;
      m_gcr = 0; m_tcr = 0; m_ccr = 0; m_bc = 0; m_tc = 0;
      engine_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].rd);
      // random part: mostly well formed bursts with random content
      k = dir_rows.size();
      while (k < 400) begin
         if ($urandom_range(0, 3) != 0) begin
            int nb, nt;
            nb = $urandom_range(0, 3) == 0 ? $urandom_range(4, 6) : $urandom_range(0, 3);
            nt = $urandom_range(0, nb + 1);
            w = '{OP_WRITE, ADDR_GCR, {1'b0, 31'($urandom)} | 32'h1, 1'b0};
            send_word(w, 0, 0);
            w = '{OP_WRITE, ADDR_CCR, ($urandom_range(0, 1) << 12) |
                  ($urandom_range(0, 2) << 8) | $urandom_range(0, 2), 1'b0};
            send_word(w, 0, 0);
            w = '{OP_WRITE, ADDR_BC, 32'(nb), 1'b0}; send_word(w, 0, 0);
            w = '{OP_WRITE, ADDR_TC, 32'(nt), 1'b0}; send_word(w, 0, 0);
            repeat (nt) begin
               w = '{OP_WRITE, ADDR_TXD, $urandom, 1'b0}; send_word(w, 0, 0);
            end
            w = '{OP_WRITE, ADDR_TCR, 32'h80000000 | ($urandom & 32'h7fffffff), 1'b0};
            send_word(w, 0, 0);
            k += 5 + nt;
            // ticks with some reads mixed in until the burst should be over
            for (int t = 0; t < nb * 8 * 2 * 5 + 4; t++) begin
               if ($urandom_range(0, 15) == 0) w = '{OP_READ, pick_addr(), 0, 1'b0};
               else w = '{OP_TICK, 10'($urandom), $urandom, 1'($urandom)};
               send_word(w, 0, 0);
               k++;
               if (!m_tcr[31] && $urandom_range(0, 3) == 0) break;
            end
            repeat ($urandom_range(0, nb + 1)) begin
               w = '{OP_READ, ADDR_RXD, $urandom, 1'b0}; send_word(w, 0, 0); k++;
            end
         end else begin
            // noise
            repeat ($urandom_range(1, 8)) begin
               w = '{2'($urandom_range(0, 3)), pick_addr(), $urandom, 1'($urandom)};
               if (w.op == OP_WRITE && w.address == ADDR_GCR && $urandom_range(0, 1))
                  w.write_data[31] = 1'b0;
               send_word(w, 0, 0);
               k++;
            end
         end
         // fill the tx fifo past full once while the receiver holds off
         if (k > 200 && !hold_long) begin
            hold_long = 1'b1;
            repeat (QUEUE_DEPTH + 8) begin
               w = '{OP_WRITE, ADDR_TXD, $urandom, 1'b0}; send_word(w, 0, 0); k++;
            end
            w = '{OP_WRITE, ADDR_FCR, 32'h80000000, 1'b0}; send_word(w, 0, 0); k++;
         end
      end
      req_chan.valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d words, %0d bursts started, %0d receive pops", n_sent, n_bursts,
               n_pops);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // receiver: random stalls plus one long hold-off
   initial begin
      int stall;
      logic done_long;
      done_long = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_long && !done_long) begin
            done_long = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (60) @(posedge clock);
         end
         stall = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 3);
         if ($urandom_range(0, 2) == 0) stall = 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // checker samples at the edge, handshake seen with pre-edge values
   always @(posedge clock) begin
      line_word_type e;
      logic fx;
      logic [31:0] fv;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_lines.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
         end else begin
            e = expected_lines.pop_front();
            fx = fixed_rd.pop_front();
            fv = fixed_val.pop_front();
            if (fx) e.read_data = fv;
            n_got++;
            if (rsp_chan.read_data !== e.read_data) begin
               $error("read_data exp %h got %h", e.read_data, rsp_chan.read_data);
               errors++;
            end
            if (rsp_chan.sclk !== e.sclk) begin
               $error("sclk exp %b got %b", e.sclk, rsp_chan.sclk); errors++;
            end
            if (rsp_chan.mosi !== e.mosi) begin
               $error("mosi exp %b got %b", e.mosi, rsp_chan.mosi); errors++;
            end
            if (rsp_chan.select_lines !== e.select_lines) begin
               $error("select_lines exp %h got %h", e.select_lines,
                      rsp_chan.select_lines);
               errors++;
            end
            if (rsp_chan.busy_res !== e.busy_res) begin
               $error("busy_res exp %b got %b", e.busy_res, rsp_chan.busy_res);
               errors++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
